/* hw/rtl/q2rm_pkg.sv */
// Shared constants, types and arithmetic helpers for the quaternion-to-matrix core.
`default_nettype none
package q2rm_pkg;
	localparam int FRAC_BITS = 14;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 16;
	localparam int PROD_W    = 2 * IN_W;
	localparam int N_W       = PROD_W + 1;
	localparam int NUM_W     = PROD_W + 2;
	localparam int MAG_W     = N_W;
	localparam int T_W       = FRAC_BITS + 2;
	localparam int DIV_STEPS = FRAC_BITS + 2;
	localparam int NUM_ENT   = 9;
	localparam int SAT_INT   = (FRAC_BITS < 15) ? (2 ** FRAC_BITS) : 32767;
	localparam logic [OUT_W-1:0] SAT_LIM = OUT_W'(SAT_INT);

	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [T_W-1:0]   quo_t;

	typedef struct packed {
		mag_t [NUM_ENT-1:0] rem;
		quo_t [NUM_ENT-1:0] quo;
		logic [NUM_ENT-1:0] neg;
		logic [N_W-1:0]     nrm;
		logic               zero;
	} div_t;

	// One restoring step; the first step compares without the shift.
	function automatic logic [MAG_W:0] div_step(input mag_t r, input logic [N_W-1:0] n,
			input logic first);
		logic [MAG_W:0] a;
		logic           b;
		mag_t           ro;
		a  = first ? {1'b0, r} : {r, 1'b0};
		b  = (a >= {1'b0, n});
		ro = b ? MAG_W'(a - {1'b0, n}) : a[MAG_W-1:0];
		return {ro, b};
	endfunction

	// Round half away from zero, clamp, apply sign; identity on zero norm.
	function automatic logic [OUT_W-1:0] finish(input quo_t t, input logic neg,
			input logic zero, input logic diag);
		logic [T_W:0]     rq;
		logic [OUT_W-1:0] mg;
		rq = ({1'b0, t} + (T_W+1)'(1)) >> 1;
		if (rq > (T_W+1)'(SAT_INT))
			mg = SAT_LIM;
		else
			mg = OUT_W'(rq);
		if (zero)
			return diag ? SAT_LIM : '0;
		return neg ? (~mg + OUT_W'(1)) : mg;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/quaternion_to_rotation_matrix_core.sv */
// Quaternion to 3x3 rotation matrix, fully pipelined fixed-point core.
// Throughput: one item per cycle while out_ready is high.
// The restoring divider resolves one quotient bit per stage.
// Stalls back up stage by stage; bubbles collapse so input keeps flowing while output waits.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module quaternion_to_rotation_matrix_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [q2rm_pkg::IN_W-1:0]  qw,
	input  wire logic signed [q2rm_pkg::IN_W-1:0]  qx,
	input  wire logic signed [q2rm_pkg::IN_W-1:0]  qy,
	input  wire logic signed [q2rm_pkg::IN_W-1:0]  qz,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m00,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m01,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m02,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m10,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m11,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m12,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m20,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m21,
	output logic signed [q2rm_pkg::OUT_W-1:0]      m22,
	output logic                                   zero_norm
);
	import q2rm_pkg::*;

	// Stage map: 0 products, 1 numerators/norm, 2..DIV_STEPS+1 divide steps, last output.
	localparam int NSTG = DIV_STEPS + 3;
	localparam int LAST = NSTG - 1;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	// Each stage loads when empty or when the stage after it moves on.
	always_comb begin
		adv[LAST] = ~vld_q[LAST] | out_ready;
		for (int k = LAST - 1; k >= 0; k--)
			adv[k] = ~vld_q[k] | adv[k+1];
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// Stage 0: the ten products.
	logic signed [PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [PROD_W-1:0] wx_s1, wy_s1, wz_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ww_s1 <= qw * qw;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			xy_s1 <= qx * qy;
			xz_s1 <= qx * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			wy_s1 <= qw * qy;
			wz_s1 <= qw * qz;
		end
	end

	// Stage 1: squared norm and the nine numerators (all |num| <= N).
	logic signed [NUM_W-1:0] eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
	logic signed [NUM_W-1:0] num [NUM_ENT];
	logic [N_W-1:0]          nrm;
	div_t                    pre;

	always_comb begin
		eww = NUM_W'(ww_s1);
		exx = NUM_W'(xx_s1);
		eyy = NUM_W'(yy_s1);
		ezz = NUM_W'(zz_s1);
		exy = NUM_W'(xy_s1);
		exz = NUM_W'(xz_s1);
		eyz = NUM_W'(yz_s1);
		ewx = NUM_W'(wx_s1);
		ewy = NUM_W'(wy_s1);
		ewz = NUM_W'(wz_s1);
		nrm = N_W'(eww + exx + eyy + ezz);
		num[0] = eww + exx - eyy - ezz;
		num[1] = (exy - ewz) <<< 1;
		num[2] = (exz + ewy) <<< 1;
		num[3] = (exy + ewz) <<< 1;
		num[4] = eww - exx + eyy - ezz;
		num[5] = (eyz - ewx) <<< 1;
		num[6] = (exz - ewy) <<< 1;
		num[7] = (eyz + ewx) <<< 1;
		num[8] = eww - exx - eyy + ezz;
		for (int i = 0; i < NUM_ENT; i++) begin
			pre.neg[i] = num[i][NUM_W-1];
			pre.rem[i] = num[i][NUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
			pre.quo[i] = '0;
		end
		pre.nrm  = nrm;
		pre.zero = (nrm == '0);
	end

	// Divider pipe: entry 0 holds stage 1, entry k holds k quotient bits.
	div_t div_s [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv[1])
			div_s[0] <= pre;
	end

	for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_div
		div_t           nxt;
		logic [MAG_W:0] st [NUM_ENT];

		always_comb begin
			nxt = div_s[g-1];
			for (int i = 0; i < NUM_ENT; i++) begin
				st[i]      = div_step(div_s[g-1].rem[i], div_s[g-1].nrm, (g == 1));
				nxt.rem[i] = st[i][MAG_W:1];
				nxt.quo[i] = {div_s[g-1].quo[i][T_W-2:0], st[i][0]};
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g+1])
				div_s[g] <= nxt;
		end
	end

	// Output stage: rounding, clamp, sign, zero-norm override.
	logic [OUT_W-1:0] res_s [NUM_ENT];
	logic             zero_s;

	always_ff @(posedge clk) begin
		if (adv[LAST]) begin
			for (int i = 0; i < NUM_ENT; i++)
				res_s[i] <= finish(div_s[DIV_STEPS].quo[i], div_s[DIV_STEPS].neg[i],
					div_s[DIV_STEPS].zero, (i == 0) || (i == 4) || (i == 8));
			zero_s <= div_s[DIV_STEPS].zero;
		end
	end

	assign m00       = res_s[0];
	assign m01       = res_s[1];
	assign m02       = res_s[2];
	assign m10       = res_s[3];
	assign m11       = res_s[4];
	assign m12       = res_s[5];
	assign m20       = res_s[6];
	assign m21       = res_s[7];
	assign m22       = res_s[8];
	assign zero_norm = zero_s;
endmodule
`default_nettype wire

/* hw/rtl/q2rm_checker.sv */
// Port-level assertions for the quaternion-to-matrix core, with bind.
`default_nettype none
module q2rm_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m00,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m01,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m02,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m10,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m11,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m12,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m20,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m21,
	input wire logic signed [q2rm_pkg::OUT_W-1:0] m22,
	input wire logic                              zero_norm
);
	import q2rm_pkg::*;

	localparam logic signed [OUT_W-1:0] LIM  = SAT_LIM;
	localparam logic signed [OUT_W-1:0] NLIM = -SAT_LIM;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m12)
			&& $stable(zero_norm))
		else $error("result changed while stalled");

	a_ident_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> m00 == LIM && m11 == LIM && m22 == LIM)
		else $error("zero norm without unit diagonal");

	a_ident_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> m01 == 0 && m02 == 0 && m10 == 0 && m12 == 0
			&& m20 == 0 && m21 == 0)
		else $error("zero norm with nonzero off-diagonal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m00 <= LIM && m00 >= NLIM && m11 <= LIM && m11 >= NLIM
			&& m21 <= LIM && m21 >= NLIM)
		else $error("entry outside saturation range");
endmodule

bind quaternion_to_rotation_matrix_core q2rm_checker u_q2rm_checker (.*);
`default_nettype wire
